>>> sv/boha_pkg.sv
// shared types, codes and reset constants for the badge occupancy hazard alarm
// no dependencies; used by every module of the block
package boha_pkg;

  localparam int IdW      = 40;
  localparam int TempW    = 8;
  localparam int HumW     = 8;
  localparam int AirW     = 12;
  localparam int NumSlots = 4;
  localparam int SlotW    = 2;
  localparam int OccW     = 3;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 40;
  localparam int InDataW  = 72;
  localparam int OutDataW = 32;

  // reset values of the limit registers
  localparam logic [TempW-1:0] TempLimitRst = 8'd45;
  localparam logic [HumW-1:0]  HumLimitRst  = 8'd85;
  localparam logic [AirW-1:0]  AirDangerRst = 12'd3200;
  localparam logic [AirW-1:0]  AirSafeRst   = 12'd2600;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgSlot0     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSlot1     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSlot2     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSlot3     = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgTempLimit = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgHumLimit  = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgAirDanger = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgAirSafe   = 3'd7;

  typedef enum logic [1:0] {
    ACT_BADGE   = 2'd0,
    ACT_CLIMATE = 2'd1,
    ACT_AIR     = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    BADGE_NONE    = 2'd0,
    BADGE_ENTRY   = 2'd1,
    BADGE_EXIT    = 2'd2,
    BADGE_UNKNOWN = 2'd3
  } badge_res_t;

  typedef enum logic [1:0] {
    EVT_NONE    = 2'd0,
    EVT_RAISED  = 2'd1,
    EVT_CLEARED = 2'd2
  } alarm_evt_t;

  // result of the slot lookup
  typedef struct packed {
    logic             hit;
    logic [SlotW-1:0] slot;
  } match_t;

  typedef logic [NumSlots-1:0][IdW-1:0] slot_arr_t;

endpackage

>>> sv/badge_occupancy_hazard_alarm.sv
// top level of the badge occupancy hazard alarm: input beat register, item
// evaluation, state and result register; depends on boha_pkg and boha_match
//
// usage
//   in_*   : one beat per item; in_tuser carries the action (badge scan,
//            climate reading, air sample), in_tdata the scan id and readings
//   out_*  : exactly one result beat per accepted item, in order
//   cfg_*  : plain register writes (badge slots and limits), taken at any
//            edge with cfg_we high; write only while the block is idle
// latency: an accepted beat lands in the input register, is evaluated in
//   the next cycle and is on out_* from the edge after acceptance
// throughput: one item per cycle; the state (presence flags, stored
//   climate, alarm flag) updates at the edge that loads the result
//   register, so the following item already sees it
// stall: while out_tvalid is high and out_tready low the result holds; the
//   input register still takes one more beat, after which in_tready drops
//   until the result beat leaves
// reset: synchronous active-low rst_n clears both valid flags, presence,
//   stored climate and alarm, and loads the limit reset values
module badge_occupancy_hazard_alarm (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // badge_id[39:0], temp_reading[47:40], hum_reading[55:48],
  // air_level[67:56], zero pad[71:68]
  input  logic [boha_pkg::InDataW-1:0]  in_tdata,
  // action[1:0]
  input  logic [1:0]                    in_tuser,
  // result channel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // badge_result[1:0], matched_slot[3:2], occupants[6:4],
  // alarm_event[8:7], alarm_active_out[9], temp_held[17:10],
  // hum_held[25:18], zero pad[31:26]
  output logic [boha_pkg::OutDataW-1:0] out_tdata,
  // item_kind[1:0]
  output logic [1:0]                    out_tuser,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [boha_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [boha_pkg::CfgDataW-1:0] cfg_wdata
);

  // configuration registers
  boha_pkg::slot_arr_t           slots_r;
  logic [boha_pkg::TempW-1:0]    temp_limit_r;
  logic [boha_pkg::HumW-1:0]     hum_limit_r;
  logic [boha_pkg::AirW-1:0]     air_danger_r;
  logic [boha_pkg::AirW-1:0]     air_safe_r;

  // input stage
  logic                          s1_valid_r;
  logic [1:0]                    s1_act_r;
  logic [boha_pkg::IdW-1:0]      s1_id_r;
  logic [boha_pkg::TempW-1:0]    s1_temp_r;
  logic [boha_pkg::HumW-1:0]     s1_hum_r;
  logic [boha_pkg::AirW-1:0]     s1_air_r;

  // block state
  logic [boha_pkg::NumSlots-1:0] presence_r, presence_nxt;
  logic [boha_pkg::TempW-1:0]    temp_r, temp_nxt;
  logic [boha_pkg::HumW-1:0]     hum_r, hum_nxt;
  logic                          alarm_r, alarm_nxt;

  // result stage
  logic                          out_valid_r;
  logic [boha_pkg::OutDataW-1:0] out_data_r, out_data_nxt;
  logic [1:0]                    out_kind_r;

  boha_pkg::match_t              match;
  boha_pkg::badge_res_t          badge_res;
  boha_pkg::alarm_evt_t          alarm_evt;
  logic [boha_pkg::SlotW-1:0]    slot_out;
  logic [boha_pkg::OccW-1:0]     occ;
  logic                          danger;
  logic                          advance;
  logic                          in_fire;

  // move the input beat into the result register when that slot frees up
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r      <= '0;
      temp_limit_r <= boha_pkg::TempLimitRst;
      hum_limit_r  <= boha_pkg::HumLimitRst;
      air_danger_r <= boha_pkg::AirDangerRst;
      air_safe_r   <= boha_pkg::AirSafeRst;
    end else if (cfg_we) begin
      case (cfg_index)
        boha_pkg::CfgSlot0:     slots_r[0]   <= cfg_wdata[boha_pkg::IdW-1:0];
        boha_pkg::CfgSlot1:     slots_r[1]   <= cfg_wdata[boha_pkg::IdW-1:0];
        boha_pkg::CfgSlot2:     slots_r[2]   <= cfg_wdata[boha_pkg::IdW-1:0];
        boha_pkg::CfgSlot3:     slots_r[3]   <= cfg_wdata[boha_pkg::IdW-1:0];
        boha_pkg::CfgTempLimit: temp_limit_r <= cfg_wdata[boha_pkg::TempW-1:0];
        boha_pkg::CfgHumLimit:  hum_limit_r  <= cfg_wdata[boha_pkg::HumW-1:0];
        boha_pkg::CfgAirDanger: air_danger_r <= cfg_wdata[boha_pkg::AirW-1:0];
        boha_pkg::CfgAirSafe:   air_safe_r   <= cfg_wdata[boha_pkg::AirW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_act_r  <= in_tuser;
      s1_id_r   <= in_tdata[39:0];
      s1_temp_r <= in_tdata[47:40];
      s1_hum_r  <= in_tdata[55:48];
      s1_air_r  <= in_tdata[67:56];
    end
  end

  boha_match u_match (
    .id    (s1_id_r),
    .slots (slots_r),
    .match (match)
  );

  // danger uses occupancy before the item; air samples never change it
  assign danger = (|presence_r) &&
                  ((s1_air_r > air_danger_r) || (temp_r > temp_limit_r) ||
                   (hum_r > hum_limit_r));

  // evaluate one item against the current state
  always_comb begin
    presence_nxt = presence_r;
    temp_nxt     = temp_r;
    hum_nxt      = hum_r;
    alarm_nxt    = alarm_r;
    badge_res    = boha_pkg::BADGE_NONE;
    alarm_evt    = boha_pkg::EVT_NONE;
    slot_out     = '0;
    case (s1_act_r)
      boha_pkg::ACT_BADGE: begin
        if (match.hit) begin
          slot_out                 = match.slot;
          presence_nxt[match.slot] = !presence_r[match.slot];
          badge_res = presence_r[match.slot] ? boha_pkg::BADGE_EXIT
                                             : boha_pkg::BADGE_ENTRY;
        end else begin
          badge_res = boha_pkg::BADGE_UNKNOWN;
        end
      end
      boha_pkg::ACT_CLIMATE: begin
        // a zero in either reading is a failed sensor read
        if ((s1_temp_r != '0) && (s1_hum_r != '0)) begin
          temp_nxt = s1_temp_r;
          hum_nxt  = s1_hum_r;
        end
      end
      boha_pkg::ACT_AIR: begin
        if (danger) begin
          if (!alarm_r) begin
            alarm_nxt = 1'b1;
            alarm_evt = boha_pkg::EVT_RAISED;
          end
        end else if (alarm_r && (s1_air_r < air_safe_r)) begin
          alarm_nxt = 1'b0;
          alarm_evt = boha_pkg::EVT_CLEARED;
        end
      end
      default: ;  // unused action code: state untouched, no events
    endcase
  end

  // occupant count after the item
  always_comb begin
    occ = '0;
    for (int i = 0; i < boha_pkg::NumSlots; i++) begin
      occ = occ + boha_pkg::OccW'(presence_nxt[i]);
    end
  end

  assign out_data_nxt = {6'd0, hum_nxt, temp_nxt, alarm_nxt, alarm_evt, occ,
                         slot_out, badge_res};

  // state commits together with the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      presence_r <= '0;
      temp_r     <= '0;
      hum_r      <= '0;
      alarm_r    <= 1'b0;
    end else if (advance) begin
      presence_r <= presence_nxt;
      temp_r     <= temp_nxt;
      hum_r      <= hum_nxt;
      alarm_r    <= alarm_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
      out_kind_r <= s1_act_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

endmodule

>>> sv/boha_match.sv
// badge slot lookup: four parallel id compares with slot zero taking priority
// depends on boha_pkg
module boha_match (
  input  logic [boha_pkg::IdW-1:0] id,
  input  boha_pkg::slot_arr_t      slots,
  output boha_pkg::match_t         match
);

  logic [boha_pkg::NumSlots-1:0] eq;

  always_comb begin
    for (int i = 0; i < boha_pkg::NumSlots; i++) begin
      eq[i] = (slots[i] == id);
    end
  end

  // lowest equal slot wins
  always_comb begin
    match.hit  = |eq;
    match.slot = '0;
    for (int i = boha_pkg::NumSlots - 1; i >= 0; i--) begin
      if (eq[i]) begin
        match.slot = boha_pkg::SlotW'(i);
      end
    end
  end

endmodule

>>> sv/boha_checker.sv
// port-level checks for the badge occupancy hazard alarm, bound to the top
// depends on boha_pkg and badge_occupancy_hazard_alarm
module boha_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [boha_pkg::OutDataW-1:0] out_tdata,
  input logic [1:0]                    out_tuser
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // reset empties the result register
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a raise event leaves the alarm on, a clear event leaves it off
  a_evt_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      (out_tdata[8:7] != boha_pkg::EVT_RAISED  || out_tdata[9]) &&
      (out_tdata[8:7] != boha_pkg::EVT_CLEARED || !out_tdata[9]))
    else $error("alarm event disagrees with alarm state");

  // alarm events only come from air samples, badge fields only from scans
  a_kind_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != boha_pkg::ACT_BADGE |->
      out_tdata[3:0] == 4'd0 &&
      (out_tuser == boha_pkg::ACT_AIR || out_tdata[8:7] == boha_pkg::EVT_NONE))
    else $error("result fields inconsistent with item kind");

  // occupancy never exceeds the slot count
  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[6:4] <= 3'd4)
    else $error("occupant count out of range");

endmodule

bind badge_occupancy_hazard_alarm boha_checker u_boha_checker (.*);
